// ===== hdl/lomx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lomx_pkg;

	// Series limits and fixed-point format
	localparam int MAX_TERMS = 1024;
	localparam int FRAC_BITS = 15;
	localparam int IN_FRAC   = 15;

	// Port widths fixed by the interface
	localparam int ARG_W     = 16;
	localparam int TOL_W     = 15;
	localparam int SUM_OUT_W = 24;
	localparam int CNT_OUT_W = 11;

	// Internal widths
	localparam int MAG_W  = FRAC_BITS + 1;                 // term magnitude, up to 1.0
	localparam int N_W    = $clog2(MAX_TERMS + 1);         // term index
	localparam int MB_W   = (N_W > MAG_W) ? N_W : MAG_W;   // second multiplier operand
	localparam int PROD_W = MAG_W + MB_W;
	localparam int DVD_W  = MAG_W + N_W;                   // dividend of the term divide
	localparam int SUM_W  = MAG_W + N_W + 1;               // signed running sum
	localparam int UP_SH  = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
	localparam int DN_SH  = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
	localparam int SM_W   = SUM_W + DN_SH;

	// Rounding constants
	localparam logic [ARG_W:0]    RND_IN  = (ARG_W + 1)'((1 << DN_SH) >> 1);
	localparam logic [SUM_W-1:0]  RND_OUT = SUM_W'((1 << UP_SH) >> 1);
	localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (FRAC_BITS - 1);

	// Output saturation bounds
	localparam logic [SM_W-1:0] SUM_POS_MAX = SM_W'((1 << (SUM_OUT_W - 1)) - 1);
	localparam logic [SM_W-1:0] SUM_NEG_MAX = SM_W'(1 << (SUM_OUT_W - 1));

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(33);

	// Result handed from the core to the output register
	typedef struct packed {
		logic [SUM_OUT_W-1:0] sum;
		logic [CNT_OUT_W-1:0] count;
		logic                 hit;
	} lomx_res_t;

	// Bring a Q1.15 magnitude to FRAC_BITS fraction bits, rounding half up
	function automatic logic [MAG_W-1:0] scale_in(input logic [ARG_W-1:0] m);
		logic [ARG_W:0] t;
		begin
			t = {1'b0, m} + RND_IN;
			if (FRAC_BITS >= IN_FRAC)
				scale_in = MAG_W'(m) << UP_SH;
			else
				scale_in = MAG_W'(t >> DN_SH);
		end
	endfunction

	// Bring the sum magnitude back to 15 fraction bits, rounding half up
	function automatic logic [SM_W-1:0] scale_out(input logic [SUM_W-1:0] m);
		logic [SUM_W-1:0] t;
		begin
			t = m + RND_OUT;
			if (FRAC_BITS >= IN_FRAC)
				scale_out = SM_W'(t >> UP_SH);
			else
				scale_out = SM_W'(m) << DN_SH;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/lomx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit a cycle. The caller guarantees the
// quotient fits MAG_W bits, so the top part of the dividend is below the divisor.
module lomx_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lomx_pkg::DVD_W-1:0] dividend,
	input  wire logic [lomx_pkg::N_W-1:0]   divisor,
	output logic                            done,
	output logic [lomx_pkg::MAG_W-1:0]      quot
);
	import lomx_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   rem_q;
	logic [N_W-1:0]   dvs_q;
	logic [MAG_W-1:0] acc_q;
	logic [N_W:0]     trial;
	logic             ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, acc_q[MAG_W-1]};
		ge    = trial >= {1'b0, dvs_q};
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVD_W-1:MAG_W];
			acc_q <= dividend[MAG_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? N_W'(trial - {1'b0, dvs_q}) : trial[N_W-1:0];
			acc_q <= {acc_q[MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

`default_nettype wire

// ===== hdl/lomx_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Series sequencer: one shared multiplier and the serial divider work each term
module lomx_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lomx_pkg::ARG_W-1:0] arg_x,
	input  wire logic [lomx_pkg::TOL_W-1:0] tolerance,
	input  wire logic                       ack,
	output logic                            idle,
	output logic                            done,
	output lomx_pkg::lomx_res_t             res
);
	import lomx_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL1 = 8'b0000_0010,
		ST_RND  = 8'b0000_0100,
		ST_MUL2 = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_WAIT = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic                    xneg_q;
	logic [MAG_W-1:0]        xm_q;
	logic [MAG_W-1:0]        tolm_q;
	logic [MAG_W-1:0]        am_q;
	logic                    aneg_q;
	logic [MAG_W-1:0]        m1_q;
	logic [PROD_W-1:0]       prod_q;
	logic [N_W-1:0]          n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    hit_q;
	lomx_res_t               res_q;

	logic [ARG_W-1:0]        raw_mag;
	logic [MAG_W-1:0]        x_in;
	logic [MAG_W-1:0]        mul_a;
	logic [MB_W-1:0]         mul_b;
	logic [DVD_W-1:0]        dividend;
	logic                    div_start;
	logic                    div_done;
	logic [MAG_W-1:0]        quot;
	logic                    tneg;
	logic signed [SUM_W-1:0] qext;
	logic                    sneg;
	logic [SUM_W-1:0]        sabs;
	logic [SM_W-1:0]         smag;
	logic [SM_W-1:0]         ssat;

	// Magnitude of the incoming argument
	always_comb begin
		raw_mag = arg_x[ARG_W-1] ? (ARG_W'(0) - arg_x) : arg_x;
		x_in    = scale_in(raw_mag);
	end

	// Operand select for the shared multiplier
	always_comb begin
		if (state_q == ST_MUL1) begin
			mul_a = am_q;
			mul_b = MB_W'(xm_q);
		end else begin
			mul_a = m1_q;
			mul_b = MB_W'(n_q - 1'b1);
		end
	end

	// Divide by the term index, rounding half up
	assign dividend  = DVD_W'(prod_q) + DVD_W'(n_q >> 1);
	assign div_start = (state_q == ST_DIV);

	lomx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quot     (quot)
	);

	// Signed new term
	always_comb begin
		tneg = (aneg_q ^ xneg_q) && (quot != '0);
		qext = $signed({{(SUM_W - MAG_W){1'b0}}, quot});
	end

	// Final rescale and saturation of the sum
	always_comb begin
		sneg = sum_q[SUM_W-1];
		sabs = sneg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		smag = scale_out(sabs);
		if (sneg)
			ssat = (smag > SUM_NEG_MAX) ? SUM_NEG_MAX : smag;
		else
			ssat = (smag > SUM_POS_MAX) ? SUM_POS_MAX : smag;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_RND;
				ST_RND:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done) begin
						if (quot < tolm_q || n_q >= N_W'(MAX_TERMS))
							state_q <= ST_FIN;
						else
							state_q <= ST_MUL1;
					end
				end
				ST_FIN:  state_q <= ST_DONE;
				ST_DONE: if (ack) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					xneg_q <= arg_x[ARG_W-1];
					xm_q   <= x_in;
					tolm_q <= scale_in({1'b0, tolerance});
					am_q   <= x_in;
					aneg_q <= arg_x[ARG_W-1] && (x_in != '0);
					sum_q  <= (arg_x[ARG_W-1] && (x_in != '0))
						? -$signed({{(SUM_W - MAG_W){1'b0}}, x_in})
						: $signed({{(SUM_W - MAG_W){1'b0}}, x_in});
					n_q    <= N_W'(1);
					hit_q  <= 1'b0;
				end
			end
			ST_MUL1: begin
				prod_q <= mul_a * mul_b;
				n_q    <= n_q + 1'b1;
			end
			ST_RND: begin
				m1_q <= MAG_W'((prod_q + HALF) >> FRAC_BITS);
			end
			ST_MUL2: begin
				prod_q <= mul_a * mul_b;
			end
			ST_WAIT: begin
				if (div_done) begin
					am_q   <= quot;
					aneg_q <= tneg;
					sum_q  <= tneg ? sum_q - qext : sum_q + qext;
					hit_q  <= (quot >= tolm_q) && (n_q >= N_W'(MAX_TERMS));
				end
			end
			ST_FIN: begin
				res_q.sum   <= sneg ? SUM_OUT_W'(SM_W'(0) - ssat) : SUM_OUT_W'(ssat);
				res_q.count <= CNT_OUT_W'(n_q);
				res_q.hit   <= hit_q;
			end
			default: ;
		endcase
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = res_q;

endmodule

`default_nettype wire

// ===== hdl/log_one_minus_x_series.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each input word gives one result word after N terms of the series (2 to MAX_TERMS).
// Each term after the first passes through the multiply, round and multiply states, a divider
// load state, the 16-step serial divider and an accumulate into the sum.
// One argument at a time; the next word is taken in the cycle after the result enters the
// output register.
// Reset (arst_n low) empties the core and output register and sets tolerance to 33.
module log_one_minus_x_series (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [2:0]                       paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [lomx_pkg::ARG_W-1:0]       arg_x,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [lomx_pkg::SUM_OUT_W-1:0]        series_sum,
	output logic [lomx_pkg::CNT_OUT_W-1:0]        term_count,
	output logic                                  hit_limit
);
	import lomx_pkg::*;

	localparam logic ADDR_TOL = 1'b0;

	logic [TOL_W-1:0] tol_q;
	logic             out_valid_q;
	lomx_res_t        out_q;
	logic             core_idle;
	logic             core_done;
	logic             take;
	lomx_res_t        core_res;

	// Tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_TOL) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_TOL) ? 32'(tol_q) : 32'd0;

	lomx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid),
		.arg_x     (arg_x),
		.tolerance (tol_q),
		.ack       (take),
		.idle      (core_idle),
		.done      (core_done),
		.res       (core_res)
	);

	// Move the finished word into the output register when it is free
	assign take = core_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= core_res;
	end

	assign in_ready   = core_idle;
	assign out_valid  = out_valid_q;
	assign series_sum = out_q.sum;
	assign term_count = out_q.count;
	assign hit_limit  = out_q.hit;

endmodule

`default_nettype wire

// ===== hdl/lomx_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lomx_chk (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic                             in_ready,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic [lomx_pkg::SUM_OUT_W-1:0]   series_sum,
	input  wire logic [lomx_pkg::CNT_OUT_W-1:0]   term_count,
	input  wire logic                             hit_limit
);
	import lomx_pkg::*;

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(series_sum)
			&& $stable(term_count) && $stable(hit_limit))
		else $error("result word changed while stalled");

	// An accepted argument keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// The limit flag only comes with the full term count
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_limit |-> term_count == CNT_OUT_W'(MAX_TERMS))
		else $error("limit flag with short term count");

	// A new result follows a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind log_one_minus_x_series lomx_chk u_lomx_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.series_sum (series_sum),
	.term_count (term_count),
	.hit_limit  (hit_limit)
);

`default_nettype wire

// ===== tb/log_series_checker.sv =====
`timescale 1ns / 1ps

module log_series_checker #(
	parameter logic [2:0] TOL_ADDR = 3'd0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [2:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	input  wire logic [31:0]                       prdata,
	input  wire logic                              pready,
	input  wire logic                              in_valid,
	input  wire logic                              in_ready,
	input  wire logic [lomx_pkg::ARG_W-1:0]        arg_x,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic [lomx_pkg::SUM_OUT_W-1:0]    series_sum,
	input  wire logic [lomx_pkg::CNT_OUT_W-1:0]    term_count,
	input  wire logic                              hit_limit,
	output int                                     fails,
	output int                                     pending,
	output int                                     results_checked,
	output int                                     limit_stops
);

	import lomx_pkg::*;

	lomx_res_t            expected_sums[$];
	logic [TOL_W-1:0]     tolerance;
	lomx_res_t            want;

	initial begin
		fails = 0;
		pending = 0;
		results_checked = 0;
		limit_stops = 0;
	end

	// Print one line per mismatch (first few only) and count it
	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned exp_val);
		if (fails < 25)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
				exp_val);
		fails++;
	endtask

	// Move a magnitude between fraction widths, rounding half up when narrowing
	function automatic longint unsigned align_frac(input longint unsigned m, input int from,
			input int to);
		if (to >= from)
			return m << (to - from);
		return (m + (64'd1 << (from - to - 1))) >> (from - to);
	endfunction

	// Sum the series for one argument under the given tolerance
	function automatic lomx_res_t predict_log(input logic [ARG_W-1:0] x,
			input logic [TOL_W-1:0] tol);
		longint unsigned xm, tm, am, sm;
		longint          acc;
		bit              xneg, aneg, sneg, hit, done;
		int unsigned     n;
		lomx_res_t       r;
		xneg = x[ARG_W-1];
		xm = xneg ? (64'h10000 - 64'(x)) : 64'(x);
		xm = align_frac(xm, IN_FRAC, FRAC_BITS);
		tm = align_frac(64'(tol), IN_FRAC, FRAC_BITS);
		am = xm;
		aneg = xneg && am != 0;
		acc = aneg ? -longint'(am) : longint'(am);
		n = 1;
		hit = 0;
		done = 0;
		// Derive each term from the last: times x, times (n-1)/n
		while (!done) begin
			n++;
			am = (am * xm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			am = (am * 64'(n - 1) + 64'(n / 2)) / 64'(n);
			aneg = (aneg != xneg) && am != 0;
			acc += aneg ? -longint'(am) : longint'(am);
			if (am < tm)
				done = 1;
			else if (n >= MAX_TERMS) begin
				hit = 1;
				done = 1;
			end
		end
		// Round back to Q8.15 and saturate
		sneg = acc < 0;
		sm = sneg ? longint'(-acc) : longint'(acc);
		sm = align_frac(sm, FRAC_BITS, IN_FRAC);
		if (sneg) begin
			if (sm > 64'd8388608)
				sm = 64'd8388608;
			r.sum = SUM_OUT_W'(64'd0 - sm);
		end else begin
			if (sm > 64'd8388607)
				sm = 64'd8388607;
			r.sum = SUM_OUT_W'(sm);
		end
		r.count = CNT_OUT_W'(n);
		r.hit = hit;
		return r;
	endfunction

	// Track the register, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance = TOL_RESET;
			expected_sums.delete();
		end else begin
			if (psel && penable && pready && !pwrite && paddr == TOL_ADDR &&
					prdata !== 32'(tolerance))
				report_mismatch("tolerance readback", prdata, 32'(tolerance));
			if (psel && penable && pready && pwrite && paddr == TOL_ADDR)
				tolerance = pwdata[TOL_W-1:0];
			if (in_valid && in_ready)
				expected_sums.push_back(predict_log(arg_x, tolerance));
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch("unexpected result word", series_sum, 0);
				end else begin
					want = expected_sums.pop_front();
					results_checked++;
					if (want.hit)
						limit_stops++;
					if (series_sum !== want.sum)
						report_mismatch("series_sum", series_sum, want.sum);
					if (term_count !== want.count)
						report_mismatch("term_count", term_count, want.count);
					if (hit_limit !== want.hit)
						report_mismatch("hit_limit", hit_limit, want.hit);
				end
			end
		end
		pending = expected_sums.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import lomx_pkg::*;

	localparam logic [2:0] TOL_ADDR       = 3'd0;
	localparam logic [2:0] UNUSED_ADDR    = 3'd4;
	localparam int         WATCHDOG_LIMIT = 100000;
	localparam int         DRAIN_CYCLES   = 40;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [2:0]             paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [ARG_W-1:0]       arg_x = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SUM_OUT_W-1:0]   series_sum;
	logic [CNT_OUT_W-1:0]   term_count;
	logic                   hit_limit;

	int  fails, pending, results_checked, limit_stops;
	int  args_sent = 0;
	int  settings_used = 0;
	int  stall_cnt = 0;
	bit  calm = 1'b0;

	always #5 clk = ~clk;

	log_one_minus_x_series i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .arg_x(arg_x),
		.out_valid(out_valid), .out_ready(out_ready),
		.series_sum(series_sum), .term_count(term_count), .hit_limit(hit_limit)
	);

	log_series_checker #(.TOL_ADDR(TOL_ADDR)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .arg_x(arg_x),
		.out_valid(out_valid), .out_ready(out_ready),
		.series_sum(series_sum), .term_count(term_count), .hit_limit(hit_limit),
		.fails(fails), .pending(pending), .results_checked(results_checked),
		.limit_stops(limit_stops)
	);

	// Stall the result side about a third of the time, unless in a calm stretch
	always @(negedge clk) begin
		out_ready = calm || ($urandom_range(99) >= 33);
	end

	// Abort when no word or register access moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int idle_gap();
		if (calm || $urandom_range(99) >= 33)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	// Mostly moderate arguments; some full range, a few corners
	function automatic logic [ARG_W-1:0] pick_arg(input bit narrow);
		int unsigned      roll;
		logic [ARG_W-1:0] v;
		roll = $urandom_range(99);
		if (roll < 5) begin
			case ($urandom_range(4))
				0: v = 16'h0000;
				1: v = 16'h7FFF;
				2: v = 16'h8000;
				3: v = 16'h0001;
				default: v = 16'hFFFF;
			endcase
		end else if (roll < 20 && !narrow) begin
			v = ARG_W'($urandom);
		end else begin
			v = ARG_W'($urandom_range(24576));
			if ($urandom_range(1))
				v = -v;
		end
		return v;
	endfunction

	// One APB access: setup cycle, then access cycle until pready
	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Write the tolerance with junk in the unused upper bits, then read it back
	task automatic set_tolerance(input logic [TOL_W-1:0] tol);
		apb_access(1'b1, TOL_ADDR, {17'($urandom), tol});
		apb_access(1'b0, TOL_ADDR, '0);
		settings_used++;
	endtask

	// Offer one argument word and hold it until taken
	task automatic send_arg(input logic [ARG_W-1:0] x);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		arg_x = x;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		args_sent++;
	endtask

	// Let every expected result come back before touching the register
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [TOL_W-1:0] phase_tol[7];
		int               phase_len[7];
		phase_tol = '{15'd33, TOL_W'($urandom_range(1, 32767)), 15'd1, 15'h7FFF,
			TOL_W'($urandom_range(1, 300)), TOL_W'($urandom_range(1, 32767)), 15'd0};
		phase_len = '{24, 24, 20, 24, 24, 20, 4};

		// Hold reset, then release it
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset tolerance: zero, unit steps, both ends, halves, patterns
		apb_access(1'b0, TOL_ADDR, '0);
		foreach (phase_len[i]) begin end
		send_arg(16'h0000);
		send_arg(16'h0001);
		send_arg(16'hFFFF);
		send_arg(16'h7FFF);
		send_arg(16'h8000);
		send_arg(16'h4000);
		send_arg(16'hC000);
		send_arg(16'h5555);
		send_arg(16'hAAAA);
		send_arg(16'h0003);
		drain();

		// Zero tolerance runs to the term limit
		set_tolerance(15'd0);
		send_arg(16'h0000);
		send_arg(16'h2000);
		drain();

		// Widest tolerance stops after two terms
		set_tolerance(15'h7FFF);
		send_arg(16'h7FFF);
		send_arg(16'h8000);
		send_arg(16'h0000);
		drain();

		// Finest tolerance; then a write to an unused slot must not disturb it
		set_tolerance(15'd1);
		apb_access(1'b1, UNUSED_ADDR, 32'h0000_1234);
		apb_access(1'b0, TOL_ADDR, '0);
		send_arg(16'h0000);
		send_arg(16'h2000);
		send_arg(16'hFFFD);
		drain();

		// Random arguments across a range of tolerance settings
		foreach (phase_tol[p]) begin
			set_tolerance(phase_tol[p]);
			calm = (p == 1);
			for (int k = 0; k < phase_len[p]; k++)
				send_arg(pick_arg(phase_tol[p] < 15'd4));
			drain();
		end
		calm = 1'b0;

		$display("covered %0d arguments under %0d tolerance settings", args_sent,
			settings_used);
		$display("compared %0d results, %0d of them stopped by the term limit",
			results_checked, limit_stops);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== log_one_minus_x_series.f =====
hdl/lomx_pkg.sv
hdl/lomx_div.sv
hdl/lomx_core.sv
hdl/log_one_minus_x_series.sv
hdl/lomx_chk.sv
tb/log_series_checker.sv
tb/tb.sv
